>>> rtl/rrd_pkg.sv
`timescale 1ns / 1ps
package rrd_pkg;

	localparam int MAX_PROCS = 64;
	localparam int PID_W     = $clog2(MAX_PROCS);
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);
	localparam int TIME_W    = 32;
	localparam int RES_W     = 3;
	localparam int REQ_W     = 3;
	localparam int NUM_RES   = 5;

	// Request codes carried by req_type.
	localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_EXIT    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_REQUEST = 3'd2;
	localparam logic [REQ_W-1:0] REQ_INTR    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_TIMER   = 3'd4;

	typedef logic [PID_W-1:0]  pid_t;
	typedef logic [TIME_W-1:0] time_t;

	typedef enum logic [1:0] {
		PH_ABSENT,
		PH_RUN,
		PH_READY,
		PH_BLOCK
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BACK,
		ST_BADRES,
		ST_NOTFOUND
	} status_t;

	// One process record as held in the process store.
	typedef struct packed {
		phase_t            phase;
		logic [RES_W-1:0]  res;
		time_t             since;
		time_t             run;
		time_t             rdy;
		time_t             blk;
	} rec_t;

	typedef enum logic [2:0] {
		Q_NONE,
		Q_PUSH,
		Q_FIND,
		Q_REMOVE,
		Q_POP
	} qop_t;

	typedef struct packed {
		qop_t op;
		pid_t pid;
	} q_cmd_t;

	// Control broadcast to every cell of the ready queue.
	typedef struct packed {
		logic              load;
		logic              shift;
		pid_t              pid;
		pid_t              from;
		logic [CNT_W-1:0]  tail;
	} cell_ctl_t;

	// Adds a difference to a total, sticking at the largest value.
	function automatic time_t sat_add(time_t acc, time_t d);
		logic [TIME_W:0] s;
		s = {1'b0, acc} + {1'b0, d};
		return s[TIME_W] ? '1 : s[TIME_W-1:0];
	endfunction

endpackage

>>> rtl/rrd_cell.sv
`timescale 1ns / 1ps
module rrd_cell (
	input  logic              clk,
	input  rrd_pkg::pid_t     pos,
	input  rrd_pkg::cell_ctl_t ctl,
	input  rrd_pkg::pid_t     right_pid,
	output rrd_pkg::pid_t     pid,
	output logic              hit
);
	import rrd_pkg::*;

	pid_t pid_q;

	// A cell either takes a new pid at the tail or takes its right neighbour's pid
	// when a removal closes the gap at or before it.
	always_ff @(posedge clk) begin
		if (ctl.load && (CNT_W'(pos) == ctl.tail)) begin
			pid_q <= ctl.pid;
		end else if (ctl.shift && (pos >= ctl.from)) begin
			pid_q <= right_pid;
		end
	end

	assign pid = pid_q;
	assign hit = (pid_q == ctl.pid);

endmodule

>>> rtl/rrd_queue.sv
`timescale 1ns / 1ps
module rrd_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrd_pkg::q_cmd_t               cmd,
	output rrd_pkg::pid_t                 head,
	output logic [rrd_pkg::CNT_W-1:0]     count
);
	import rrd_pkg::*;

	logic [CNT_W-1:0]     count_q;
	pid_t                 idx_q;
	logic                 found_q;
	pid_t                 idx_c;
	logic                 found_c;
	cell_ctl_t            ctl;
	pid_t                 pids   [MAX_PROCS];
	pid_t                 rights [MAX_PROCS];
	logic [MAX_PROCS-1:0] hits;

	always_comb begin
		ctl.load  = (cmd.op == Q_PUSH) && (count_q < CNT_W'(MAX_PROCS));
		ctl.shift = ((cmd.op == Q_REMOVE) && found_q) ||
		            ((cmd.op == Q_POP) && (count_q != '0));
		ctl.pid   = cmd.pid;
		ctl.from  = (cmd.op == Q_POP) ? '0 : idx_q;
		ctl.tail  = count_q;
	end

	for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
		if (i == MAX_PROCS - 1) begin : g_last
			assign rights[i] = '0;
		end else begin : g_mid
			assign rights[i] = pids[i+1];
		end
		rrd_cell u_cell (
			.clk       (clk),
			.pos       (PID_W'(i)),
			.ctl       (ctl),
			.right_pid (rights[i]),
			.pid       (pids[i]),
			.hit       (hits[i])
		);
	end

	// Pids in the queue are unique, so the matching position is an OR of indices.
	always_comb begin
		idx_c   = '0;
		found_c = 1'b0;
		for (int i = 0; i < MAX_PROCS; i++) begin
			if (hits[i] && (CNT_W'(i) < count_q)) begin
				idx_c   = idx_c | PID_W'(i);
				found_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.shift) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.op == Q_FIND) begin
				idx_q   <= idx_c;
				found_q <= found_c;
			end
		end
	end

	assign head  = pids[0];
	assign count = count_q;

endmodule

>>> rtl/rrd_table.sv
`timescale 1ns / 1ps
module rrd_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_en,
	input  rrd_pkg::pid_t  rd_addr,
	output rrd_pkg::rec_t  rd_rec,
	input  logic           wr_en,
	input  rrd_pkg::pid_t  wr_addr,
	input  rrd_pkg::rec_t  wr_rec
);
	import rrd_pkg::*;

	rec_t                 mem [MAX_PROCS];
	rec_t                 rd_q;
	logic                 rd_live_q;
	logic [MAX_PROCS-1:0] live_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_rec;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Live bits make every never-written entry read as an absent process.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= '0;
			rd_live_q <= 1'b0;
		end else begin
			if (wr_en) begin
				live_q[wr_addr] <= (wr_rec.phase != PH_ABSENT);
			end
			if (rd_en) begin
				rd_live_q <= live_q[rd_addr];
			end
		end
	end

	always_comb begin
		rd_rec = rd_q;
		if (!rd_live_q) begin
			rd_rec.phase = PH_ABSENT;
		end
	end

endmodule

>>> rtl/round_robin_dispatcher_top.sv
`timescale 1ns / 1ps
// Round-robin dispatcher: each input word is one timestamped scheduling event (create, exit,
// request a resource, resource interrupt or timer tick) and gives exactly one result word with
// the status, the pid running afterwards, the idle total and, on an exit, the totals of the
// process that left. The ready queue is a row of cells that shift towards the head, and the
// per-process records sit in a store with one read port, one write port and a registered read.
// A word is handled by a sequencer that reads and writes up to two process records, and the
// next word is accepted only once the sequencer is back in its idle state. An event settled
// by screening alone goes straight to the output: a bad timestamp, resource or pid, an unknown
// code, or a timer tick with nothing to preempt. Other events read their process record; one
// rejected there goes to the output, while a create, interrupt, exit or block writes the record
// back. Taking a ready process out of the queue adds a removal step. When the running process
// leaves, which includes a timer preemption, a dispatch step follows; if the queue is not empty
// it reads and writes the record of the head. The result sits in an output register; if it has
// not been taken, the sequencer waits there before taking the next word.
module round_robin_dispatcher_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rrd_pkg::REQ_W-1:0]   req_type,
	input  logic [rrd_pkg::TIME_W-1:0]  event_time,
	input  logic [rrd_pkg::PID_W-1:0]   proc_id,
	input  logic [rrd_pkg::RES_W-1:0]   resource_num,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [rrd_pkg::PID_W-1:0]   running_pid,
	output logic                        exit_valid,
	output logic [rrd_pkg::PID_W-1:0]   exit_pid,
	output logic [rrd_pkg::TIME_W-1:0]  exit_run_total,
	output logic [rrd_pkg::TIME_W-1:0]  exit_ready_total,
	output logic [rrd_pkg::TIME_W-1:0]  exit_block_total,
	output logic [rrd_pkg::TIME_W-1:0]  idle_total
);
	import rrd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_RD,
		S_UPD,
		S_RM,
		S_DSP,
		S_DRD,
		S_DUP,
		S_OUT
	} state_t;

	state_t            state_q;
	logic [REQ_W-1:0]  kind_q;
	time_t             t_q;
	pid_t              pid_q;
	logic [RES_W-1:0]  res_q;
	pid_t              tgt_q;
	pid_t              head_q;
	pid_t              cur_q;
	time_t             idle_acc_q;
	time_t             idle_start_q;
	time_t             idle_d_q;
	time_t             last_q;
	rec_t              rec_q;
	time_t             diff_q;
	status_t           st_q;
	logic              ex_valid_q;
	pid_t              ex_pid_q;
	time_t             ex_run_q;
	time_t             ex_rdy_q;
	time_t             ex_blk_q;

	logic              out_valid_q;
	status_t           status_q;
	pid_t              running_q;
	logic              exit_valid_q;
	pid_t              exit_pid_q;
	time_t             exit_run_q;
	time_t             exit_rdy_q;
	time_t             exit_blk_q;
	time_t             idle_total_q;

	logic              rd_en;
	pid_t              rd_addr;
	rec_t              rd_rec;
	logic              wr_en;
	pid_t              wr_addr;
	rec_t              wr_rec;
	q_cmd_t            qcmd;
	pid_t              q_head;
	logic [CNT_W-1:0]  q_count;
	time_t             sel_acc;
	time_t             acc_sum;
	logic              chk_done;
	status_t           chk_status;
	logic              out_free;

	rrd_table u_tbl (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_rec  (rd_rec),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_rec  (wr_rec)
	);

	rrd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (qcmd),
		.head   (q_head),
		.count  (q_count)
	);

	assign out_free = !out_valid_q || !out_stall;

	// Early screening of the event: order of checks follows the status priority.
	always_comb begin
		chk_done   = 1'b1;
		chk_status = ST_OK;
		if (t_q < last_q) begin
			chk_status = ST_BACK;
		end else if (((kind_q == REQ_REQUEST) || (kind_q == REQ_INTR)) &&
		             ((res_q == '0) || (res_q > RES_W'(NUM_RES)))) begin
			chk_status = ST_BADRES;
		end else if ((kind_q <= REQ_INTR) && (pid_q == '0)) begin
			chk_status = ST_NOTFOUND;
		end else if (kind_q > REQ_TIMER) begin
			chk_status = ST_OK;
		end else if ((kind_q == REQ_TIMER) && ((cur_q == '0) || (q_count == '0))) begin
			chk_status = ST_OK;
		end else begin
			chk_done = 1'b0;
		end
	end

	// The total that the current step extends; a dispatch always extends ready time.
	always_comb begin
		if (state_q == S_DUP) begin
			sel_acc = rec_q.rdy;
		end else begin
			case (kind_q)
				REQ_EXIT, REQ_REQUEST: begin
					case (rec_q.phase)
						PH_RUN:   sel_acc = rec_q.run;
						PH_READY: sel_acc = rec_q.rdy;
						default:  sel_acc = rec_q.blk;
					endcase
				end
				REQ_INTR: sel_acc = rec_q.blk;
				default:  sel_acc = rec_q.run;
			endcase
		end
		acc_sum = sat_add(sel_acc, diff_q);
	end

	// Store and queue commands issued by the sequencer.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pid_q;
		wr_en   = 1'b0;
		wr_addr = tgt_q;
		wr_rec  = rec_q;
		qcmd.op  = Q_NONE;
		qcmd.pid = tgt_q;
		case (state_q)
			S_CHK: begin
				rd_en   = !chk_done;
				rd_addr = (kind_q == REQ_TIMER) ? cur_q : pid_q;
			end
			S_UPD: begin
				wr_en        = 1'b1;
				wr_rec.since = t_q;
				case (kind_q)
					REQ_CREATE: begin
						wr_rec.run   = '0;
						wr_rec.rdy   = '0;
						wr_rec.blk   = '0;
						wr_rec.phase = (cur_q == '0) ? PH_RUN : PH_READY;
						if (cur_q != '0) begin
							qcmd.op = Q_PUSH;
						end
					end
					REQ_INTR: begin
						wr_rec.blk   = acc_sum;
						wr_rec.phase = (cur_q == '0) ? PH_RUN : PH_READY;
						if (cur_q != '0) begin
							qcmd.op = Q_PUSH;
						end
					end
					REQ_EXIT, REQ_REQUEST: begin
						case (rec_q.phase)
							PH_RUN:   wr_rec.run = acc_sum;
							PH_READY: wr_rec.rdy = acc_sum;
							default:  wr_rec.blk = acc_sum;
						endcase
						if (kind_q == REQ_EXIT) begin
							wr_rec.phase = PH_ABSENT;
						end else begin
							wr_rec.phase = PH_BLOCK;
							wr_rec.res   = res_q;
						end
						if (rec_q.phase == PH_READY) begin
							qcmd.op = Q_FIND;
						end
					end
					default: begin
						// Timer preemption: the running process goes to the tail.
						wr_rec.run   = acc_sum;
						wr_rec.phase = PH_READY;
						qcmd.op      = Q_PUSH;
					end
				endcase
			end
			S_RM: begin
				qcmd.op = Q_REMOVE;
			end
			S_DSP: begin
				rd_addr = q_head;
				if (q_count != '0) begin
					rd_en   = 1'b1;
					qcmd.op = Q_POP;
				end
			end
			S_DUP: begin
				wr_en        = 1'b1;
				wr_addr      = head_q;
				wr_rec.rdy   = acc_sum;
				wr_rec.since = t_q;
				wr_rec.phase = PH_RUN;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			kind_q       <= '0;
			t_q          <= '0;
			pid_q        <= '0;
			res_q        <= '0;
			tgt_q        <= '0;
			head_q       <= '0;
			cur_q        <= '0;
			idle_acc_q   <= '0;
			idle_start_q <= '0;
			idle_d_q     <= '0;
			last_q       <= '0;
			rec_q        <= '0;
			diff_q       <= '0;
			st_q         <= ST_OK;
			ex_valid_q   <= 1'b0;
			ex_pid_q     <= '0;
			ex_run_q     <= '0;
			ex_rdy_q     <= '0;
			ex_blk_q     <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_OK;
			running_q    <= '0;
			exit_valid_q <= 1'b0;
			exit_pid_q   <= '0;
			exit_run_q   <= '0;
			exit_rdy_q   <= '0;
			exit_blk_q   <= '0;
			idle_total_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && !((state_q == S_OUT) && out_free)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= req_type;
						t_q     <= event_time;
						pid_q   <= proc_id;
						res_q   <= resource_num;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					st_q       <= chk_status;
					ex_valid_q <= 1'b0;
					ex_pid_q   <= '0;
					ex_run_q   <= '0;
					ex_rdy_q   <= '0;
					ex_blk_q   <= '0;
					idle_d_q   <= t_q - idle_start_q;
					tgt_q      <= (kind_q == REQ_TIMER) ? cur_q : pid_q;
					if (!(t_q < last_q)) begin
						last_q <= t_q;
					end
					state_q <= chk_done ? S_OUT : S_RD;
				end
				S_RD: begin
					rec_q   <= rd_rec;
					diff_q  <= t_q - rd_rec.since;
					state_q <= S_UPD;
					case (kind_q)
						REQ_CREATE: begin
							if (rd_rec.phase != PH_ABSENT) begin
								st_q    <= ST_NOTFOUND;
								state_q <= S_OUT;
							end
						end
						REQ_EXIT, REQ_REQUEST: begin
							if (rd_rec.phase == PH_ABSENT) begin
								st_q    <= ST_NOTFOUND;
								state_q <= S_OUT;
							end
						end
						REQ_INTR: begin
							if ((rd_rec.phase != PH_BLOCK) || (rd_rec.res != res_q)) begin
								st_q    <= ST_NOTFOUND;
								state_q <= S_OUT;
							end
						end
						default: begin
						end
					endcase
				end
				S_UPD: begin
					state_q <= S_OUT;
					case (kind_q)
						REQ_CREATE, REQ_INTR: begin
							if (cur_q == '0) begin
								idle_acc_q <= sat_add(idle_acc_q, idle_d_q);
								cur_q      <= tgt_q;
							end
						end
						REQ_EXIT, REQ_REQUEST: begin
							if (kind_q == REQ_EXIT) begin
								ex_valid_q <= 1'b1;
								ex_pid_q   <= tgt_q;
								ex_run_q   <= wr_rec.run;
								ex_rdy_q   <= wr_rec.rdy;
								ex_blk_q   <= wr_rec.blk;
							end
							if (rec_q.phase == PH_READY) begin
								state_q <= S_RM;
							end else if (rec_q.phase == PH_RUN) begin
								state_q <= S_DSP;
							end
						end
						default: begin
							state_q <= S_DSP;
						end
					endcase
				end
				S_RM: begin
					state_q <= S_OUT;
				end
				S_DSP: begin
					if (q_count != '0) begin
						head_q  <= q_head;
						state_q <= S_DRD;
					end else begin
						cur_q        <= '0;
						idle_start_q <= t_q;
						state_q      <= S_OUT;
					end
				end
				S_DRD: begin
					rec_q   <= rd_rec;
					diff_q  <= t_q - rd_rec.since;
					state_q <= S_DUP;
				end
				S_DUP: begin
					cur_q   <= head_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						status_q     <= st_q;
						running_q    <= cur_q;
						exit_valid_q <= ex_valid_q;
						exit_pid_q   <= ex_pid_q;
						exit_run_q   <= ex_run_q;
						exit_rdy_q   <= ex_rdy_q;
						exit_blk_q   <= ex_blk_q;
						idle_total_q <= idle_acc_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall         = (state_q != S_IDLE);
	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign running_pid      = running_q;
	assign exit_valid       = exit_valid_q;
	assign exit_pid         = exit_pid_q;
	assign exit_run_total   = exit_run_q;
	assign exit_ready_total = exit_rdy_q;
	assign exit_block_total = exit_blk_q;
	assign idle_total       = idle_total_q;

	// An accepted word always starts with the screening step.
	a_accept_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_CHK))
		else $error("accepted word did not enter screening");

	// The ready queue never holds more entries than there are processes.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CNT_W'(MAX_PROCS))
		else $error("ready queue count out of range");

	// A reported exit is always a successful event.
	a_exit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && exit_valid_q) |-> (status_q == ST_OK))
		else $error("exit reported with an error status");

	// A dispatched queue head is never the idle pid.
	a_head_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUP) |-> (head_q != '0))
		else $error("dispatch of the idle pid");

	// A result leaves the sequencer only once the output register can take it.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_OUT) && out_free) |=> (out_valid_q && (state_q == S_IDLE)))
		else $error("result not loaded into the output register");

endmodule
